// ===== src/tdbh_pkg.sv =====
// ----------------------------------------------------------------------------
// tdbh_pkg
// Shared types and register codes for the capacitive touch detector with
// baseline tracking and hysteresis.
// ----------------------------------------------------------------------------
package tdbh_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int RAW_WIDTH       = 16;
    localparam int CALIB_CNT_WIDTH = 9;
    localparam int CALIB_SUM_WIDTH = 24;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TOUCH_OFFSET   = 3'd0,
        CFG_RELEASE_OFFSET = 3'd1,
        CFG_TOUCH_RUN      = 3'd2,
        CFG_RELEASE_RUN    = 3'd3,
        CFG_BLEND_SHIFT    = 3'd4,
        CFG_WARMUP_COUNT   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] touch_offset;
        logic [15:0] release_offset;
        logic [7:0]  touch_run;
        logic [7:0]  release_run;
        logic [3:0]  blend_shift;
        logic [7:0]  warmup_count;
    } cfg_t;

    typedef struct packed {
        logic        is_touched;
        logic [15:0] baseline_value;
        logic        calibrating;
    } result_t;

endpackage

// ===== src/touch_detect_baseline_hysteresis.sv =====
// ----------------------------------------------------------------------------
// touch_detect_baseline_hysteresis
// Capacitive touch detector: warmup and averaged baseline calibration, then
// touch and release detection with hysteresis and idle baseline tracking.
//
//   Channel  Signals                                   Direction
//   input    in_valid, in_ready, raw_count             sample in
//   output   out_valid, out_ready, is_touched,         result out
//            baseline_value, calibrating
//   config   cfg_write, cfg_index, cfg_data            register write
//
// One sample per cycle is sustained while the output is not stalled; a sample is
// held first in the input register and its result then in the result register,
// from which it transfers when out_ready is high.
// The whole update for a sample is done between those two registers.
// Reset clears all control state and loads the register defaults.
// A stalled output holds its result while one more sample waits in the input
// register; in_ready falls only when both are full.
// ----------------------------------------------------------------------------
module touch_detect_baseline_hysteresis #(
    parameter int BASELINE_SAMPLES_LOG2 = 5,
    parameter int SAMPLE_WIDTH          = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tdbh_pkg::RAW_WIDTH-1:0]        raw_count,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  is_touched,
    output logic [15:0]                           baseline_value,
    output logic                                  calibrating,
    input  logic                                  cfg_write,
    input  logic [tdbh_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tdbh_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    tdbh_pkg::cfg_t          cfg_reg;
    logic                    s1_valid_reg;
    logic [SAMPLE_WIDTH-1:0] s1_raw_reg;
    logic                    out_valid_reg;
    tdbh_pkg::result_t       result_reg;
    tdbh_pkg::result_t       result_next;
    logic                    advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_offset   <= 16'd40;
            cfg_reg.release_offset <= 16'd20;
            cfg_reg.touch_run      <= 8'd3;
            cfg_reg.release_run    <= 8'd3;
            cfg_reg.blend_shift    <= 4'd4;
            cfg_reg.warmup_count   <= 8'd16;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tdbh_pkg::CFG_TOUCH_OFFSET:   cfg_reg.touch_offset   <= cfg_data;
                tdbh_pkg::CFG_RELEASE_OFFSET: cfg_reg.release_offset <= cfg_data;
                tdbh_pkg::CFG_TOUCH_RUN:      cfg_reg.touch_run      <= cfg_data[7:0];
                tdbh_pkg::CFG_RELEASE_RUN:    cfg_reg.release_run    <= cfg_data[7:0];
                tdbh_pkg::CFG_BLEND_SHIFT:    cfg_reg.blend_shift    <= cfg_data[3:0];
                tdbh_pkg::CFG_WARMUP_COUNT:   cfg_reg.warmup_count   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_raw_reg <= raw_count[SAMPLE_WIDTH-1:0];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    tdbh_core #(
        .SAMPLE_WIDTH          (SAMPLE_WIDTH),
        .BASELINE_SAMPLES_LOG2 (BASELINE_SAMPLES_LOG2)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .raw    (s1_raw_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    assign out_valid      = out_valid_reg;
    assign is_touched     = result_reg.is_touched;
    assign baseline_value = result_reg.baseline_value;
    assign calibrating    = result_reg.calibrating;

    a_no_touch_while_calibrating: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.calibrating |-> !result_reg.is_touched
    ) else $error("touch reported during calibration");

    a_calibration_done_stays: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.calibrating |=> !result_reg.calibrating
    ) else $error("calibration restarted after completion");

    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready
    ) else $error("input stalled while a stage was free");

endmodule

// ===== src/tdbh_core.sv =====
// ----------------------------------------------------------------------------
// tdbh_core
// Detector state and per-sample update: calibration, baseline blend and
// touch/release run counting.
// ----------------------------------------------------------------------------
module tdbh_core #(
    parameter int SAMPLE_WIDTH          = 16,
    parameter int BASELINE_SAMPLES_LOG2 = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [SAMPLE_WIDTH-1:0] raw,
    input  tdbh_pkg::cfg_t          cfg,
    output tdbh_pkg::result_t       result
);

    localparam int                             ACC_WIDTH   = SAMPLE_WIDTH + 16;
    localparam int                             CW          = tdbh_pkg::CALIB_CNT_WIDTH;
    localparam int                             SW          = tdbh_pkg::CALIB_SUM_WIDTH;
    localparam logic [CW:0]                    AVG_SAMPLES = (CW + 1)'(1) << BASELINE_SAMPLES_LOG2;

    logic [SAMPLE_WIDTH-1:0] idle_level_reg, idle_level_next;
    logic                    touch_flag_reg, touch_flag_next;
    logic [7:0]              touch_streak_reg, touch_streak_next;
    logic [7:0]              release_streak_reg, release_streak_next;
    logic [CW-1:0]           calib_counter_reg, calib_counter_next;
    logic [SW-1:0]           calib_sum_reg, calib_sum_next;
    logic                    in_calibration_reg, in_calibration_next;

    logic [SAMPLE_WIDTH-1:0] blended;
    logic [SW-1:0]           sum_plus;
    logic [SW-1:0]           sum_shifted;
    logic [CW-1:0]           counter_plus;
    logic [CW:0]             avg_progress;
    logic [16:0]             touch_level;
    logic [16:0]             release_level;
    logic                    above_touch;
    logic                    above_release;
    logic [7:0]              streak_tmp;

    function automatic logic [SAMPLE_WIDTH-1:0] blend(
        input logic [SAMPLE_WIDTH-1:0] level,
        input logic [SAMPLE_WIDTH-1:0] sample,
        input logic [3:0]              k
    );
        logic [ACC_WIDTH-1:0] acc;
        logic [ACC_WIDTH-1:0] shifted;
        acc     = (ACC_WIDTH'(level) << k) - ACC_WIDTH'(level) + ACC_WIDTH'(sample);
        shifted = acc >> k;
        return shifted[SAMPLE_WIDTH-1:0];
    endfunction

    assign blended       = blend(idle_level_reg, raw, cfg.blend_shift);
    assign sum_plus      = calib_sum_reg + SW'(raw);
    assign sum_shifted   = sum_plus >> BASELINE_SAMPLES_LOG2;
    assign counter_plus  = calib_counter_reg + CW'(1);
    assign avg_progress  = {1'b0, counter_plus} - (CW + 1)'(cfg.warmup_count);
    assign touch_level   = 17'(blended) + 17'(cfg.touch_offset);
    assign release_level = 17'(idle_level_reg) + 17'(cfg.release_offset);
    assign above_touch   = 17'(raw) > touch_level;
    assign above_release = 17'(raw) > release_level;

    always_comb
    begin
        idle_level_next     = idle_level_reg;
        touch_flag_next     = touch_flag_reg;
        touch_streak_next   = touch_streak_reg;
        release_streak_next = release_streak_reg;
        calib_counter_next  = calib_counter_reg;
        calib_sum_next      = calib_sum_reg;
        in_calibration_next = in_calibration_reg;
        streak_tmp          = '0;

        if (in_calibration_reg)
        begin
            calib_counter_next = counter_plus;
            if (calib_counter_reg >= CW'(cfg.warmup_count))
            begin
                calib_sum_next = sum_plus;
                // A counter that wrapped below the warmup count also ends averaging.
                if (avg_progress >= AVG_SAMPLES)
                begin
                    idle_level_next     = sum_shifted[SAMPLE_WIDTH-1:0];
                    in_calibration_next = 1'b0;
                    touch_flag_next     = 1'b0;
                    touch_streak_next   = '0;
                    release_streak_next = '0;
                end
            end
        end
        else if (!touch_flag_reg)
        begin
            idle_level_next = blended;
            if (above_touch)
            begin
                streak_tmp = (touch_streak_reg < cfg.touch_run) ?
                             touch_streak_reg + 8'd1 : touch_streak_reg;
            end
            touch_streak_next = streak_tmp;
            if (streak_tmp >= cfg.touch_run)
            begin
                touch_flag_next     = 1'b1;
                touch_streak_next   = '0;
                release_streak_next = '0;
            end
        end
        else
        begin
            if (!above_release)
            begin
                streak_tmp = (release_streak_reg < cfg.release_run) ?
                             release_streak_reg + 8'd1 : release_streak_reg;
            end
            release_streak_next = streak_tmp;
            if (streak_tmp >= cfg.release_run)
            begin
                touch_flag_next     = 1'b0;
                release_streak_next = '0;
                touch_streak_next   = '0;
                idle_level_next     = blended;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_level_reg     <= '0;
            touch_flag_reg     <= 1'b0;
            touch_streak_reg   <= '0;
            release_streak_reg <= '0;
            calib_counter_reg  <= '0;
            calib_sum_reg      <= '0;
            in_calibration_reg <= 1'b1;
        end
        else if (step)
        begin
            idle_level_reg     <= idle_level_next;
            touch_flag_reg     <= touch_flag_next;
            touch_streak_reg   <= touch_streak_next;
            release_streak_reg <= release_streak_next;
            calib_counter_reg  <= calib_counter_next;
            calib_sum_reg      <= calib_sum_next;
            in_calibration_reg <= in_calibration_next;
        end
    end

    assign result.is_touched     = touch_flag_next;
    assign result.baseline_value = 16'(idle_level_next);
    assign result.calibrating    = in_calibration_next;

endmodule

// ===== tb/touch_detect_baseline_hysteresis_tb.sv =====
// ----------------------------------------------------------------------------
// touch_detect_baseline_hysteresis_tb
// Self-checking testbench for the capacitive touch detector. A clocked driver
// feeds raw counts from a queue and a clocked monitor predicts every result
// at the input transfer and checks each output transfer in order. The run
// covers calibration with a warmup change, directed register extremes, and
// randomized press and lift sequences with noise under varied flow control.
// ----------------------------------------------------------------------------
module touch_detect_baseline_hysteresis_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BASELINE_SAMPLES_LOG2 = 5;
    localparam int          SAMPLE_WIDTH          = 16;
    localparam logic [31:0] SAMPLE_MASK           = (32'd1 << SAMPLE_WIDTH) - 32'd1;
    localparam logic [31:0] AVG_COUNT             = 32'd1 << BASELINE_SAMPLES_LOG2;
    localparam int          CYCLE_LIMIT           = 200000;
    localparam int          RANDOM_PHASES         = 12;
    localparam int          PHASE_SAMPLES         = 45;

    logic                                 clk            = 1'b0;
    logic                                 rst_n          = 1'b0;
    logic                                 in_valid       = 1'b0;
    logic                                 in_ready;
    logic [tdbh_pkg::RAW_WIDTH-1:0]       raw_count      = '0;
    logic                                 out_valid;
    logic                                 out_ready      = 1'b0;
    logic                                 is_touched;
    logic [15:0]                          baseline_value;
    logic                                 calibrating;
    logic                                 cfg_write      = 1'b0;
    logic [tdbh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index      = '0;
    logic [tdbh_pkg::CFG_DATA_WIDTH-1:0]  cfg_data       = '0;

    logic [15:0]          pending_samples[$];
    tdbh_pkg::result_t    expected_results[$];

    tdbh_pkg::cfg_t cfg_shadow;
    logic [15:0]    idle_lvl;
    logic           touched;
    logic [7:0]     t_streak;
    logic [7:0]     r_streak;
    logic [8:0]     cal_cnt;
    logic [23:0]    cal_sum;
    logic           cal_active;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int settings_run  = 0;
    int cycle_count   = 0;

    touch_detect_baseline_hysteresis #(
        .BASELINE_SAMPLES_LOG2(BASELINE_SAMPLES_LOG2),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .raw_count(raw_count),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_touched(is_touched),
        .baseline_value(baseline_value),
        .calibrating(calibrating),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] blended(input logic [15:0] lvl, input logic [15:0] raw,
                                            input logic [3:0] k);
        logic [31:0] acc;
        acc = 32'(lvl) * ((32'd1 << k) - 32'd1) + 32'(raw);
        return 16'((acc >> k) & SAMPLE_MASK);
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    function automatic logic [7:0] pick_run();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic reset_detector();
        cfg_shadow.touch_offset   = 16'd40;
        cfg_shadow.release_offset = 16'd20;
        cfg_shadow.touch_run      = 8'd3;
        cfg_shadow.release_run    = 8'd3;
        cfg_shadow.blend_shift    = 4'd4;
        cfg_shadow.warmup_count   = 8'd16;
        idle_lvl   = '0;
        touched    = 1'b0;
        t_streak   = '0;
        r_streak   = '0;
        cal_cnt    = '0;
        cal_sum    = '0;
        cal_active = 1'b1;
    endtask

    task automatic step_detector(input logic [15:0] raw_in, output tdbh_pkg::result_t res);
        logic [15:0] raw;
        logic [31:0] span;
        raw = 16'(32'(raw_in) & SAMPLE_MASK);
        if (cal_active)
        begin
            if (32'(cal_cnt) < 32'(cfg_shadow.warmup_count))
            begin
                cal_cnt = cal_cnt + 9'd1;
            end
            else
            begin
                cal_sum = cal_sum + 24'(raw);
                cal_cnt = cal_cnt + 9'd1;
                span = 32'(cal_cnt) - 32'(cfg_shadow.warmup_count);
                if (span >= AVG_COUNT)
                begin
                    idle_lvl   = 16'((32'(cal_sum) >> BASELINE_SAMPLES_LOG2) & SAMPLE_MASK);
                    cal_active = 1'b0;
                    touched    = 1'b0;
                    t_streak   = '0;
                    r_streak   = '0;
                end
            end
        end
        else if (!touched)
        begin
            idle_lvl = blended(idle_lvl, raw, cfg_shadow.blend_shift);
            if (32'(raw) > 32'(idle_lvl) + 32'(cfg_shadow.touch_offset))
            begin
                if (t_streak < cfg_shadow.touch_run)
                    t_streak = t_streak + 8'd1;
            end
            else
            begin
                t_streak = '0;
            end
            if (t_streak >= cfg_shadow.touch_run)
            begin
                touched  = 1'b1;
                t_streak = '0;
                r_streak = '0;
            end
        end
        else
        begin
            if (32'(raw) > 32'(idle_lvl) + 32'(cfg_shadow.release_offset))
                r_streak = '0;
            else if (r_streak < cfg_shadow.release_run)
                r_streak = r_streak + 8'd1;
            if (r_streak >= cfg_shadow.release_run)
            begin
                touched  = 1'b0;
                r_streak = '0;
                t_streak = '0;
                idle_lvl = blended(idle_lvl, raw, cfg_shadow.blend_shift);
            end
        end
        res.is_touched     = touched;
        res.baseline_value = idle_lvl;
        res.calibrating    = cal_active;
    endtask

    task automatic write_reg(input tdbh_pkg::cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            tdbh_pkg::CFG_TOUCH_OFFSET:   cfg_shadow.touch_offset   = val;
            tdbh_pkg::CFG_RELEASE_OFFSET: cfg_shadow.release_offset = val;
            tdbh_pkg::CFG_TOUCH_RUN:      cfg_shadow.touch_run      = val[7:0];
            tdbh_pkg::CFG_RELEASE_RUN:    cfg_shadow.release_run    = val[7:0];
            tdbh_pkg::CFG_BLEND_SHIFT:    cfg_shadow.blend_shift    = val[3:0];
            tdbh_pkg::CFG_WARMUP_COUNT:   cfg_shadow.warmup_count   = val[7:0];
            default:                      ;
        endcase
        reg_writes++;
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_run++;
        @(negedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One press and lift around b with occasional broken runs, or one random sample.
    task automatic add_episode(input int b);
        int to;
        int ro;
        int len;
        int i;
        to = int'(cfg_shadow.touch_offset);
        ro = int'(cfg_shadow.release_offset);
        if ($urandom_range(0, 5) == 0)
        begin
            pending_samples.push_back(16'($urandom));
            return;
        end
        len = $urandom_range(0, 4);
        for (i = 0; i < len; i++)
            pending_samples.push_back(sat16(b + int'($urandom_range(0, 40)) - 20));
        len = int'(cfg_shadow.touch_run) + int'($urandom_range(0, 3));
        if (len > 20)
            len = 20;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                pending_samples.push_back(sat16(b));
            else
                pending_samples.push_back(sat16(b + to + to / 4 + 8 +
                                                int'($urandom_range(0, 200))));
        end
        len = $urandom_range(0, 5);
        for (i = 0; i < len; i++)
            pending_samples.push_back(sat16(b + ro + 1 + int'($urandom_range(0, 300))));
        len = int'(cfg_shadow.release_run) + int'($urandom_range(0, 2));
        if (len > 20)
            len = 20;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                pending_samples.push_back(sat16(b + ro + 50));
            else
                pending_samples.push_back(sat16(b + ro - int'($urandom_range(0, 30))));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            raw_count <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                raw_count <= pending_samples.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        tdbh_pkg::result_t predicted;
        tdbh_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                step_detector(raw_count, predicted);
                expected_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (is_touched !== want.is_touched)
                    begin
                        $error("is_touched: expected %0d, actual %0d",
                               want.is_touched, is_touched);
                        mismatches++;
                    end
                    if (baseline_value !== want.baseline_value)
                    begin
                        $error("baseline_value: expected %0d, actual %0d",
                               want.baseline_value, baseline_value);
                        mismatches++;
                    end
                    if (calibrating !== want.calibrating)
                    begin
                        $error("calibrating: expected %0d, actual %0d",
                               want.calibrating, calibrating);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("touch_detect_baseline_hysteresis regression: fail");
            $finish;
        end
    end

    initial
    begin : main_sequence
        int i;
        int ph;
        int b;
        logic [15:0] to_val;
        reset_detector();
        send_idle_pct = 26;
        recv_idle_pct = 49;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Warmup is lengthened, a few samples pass, then warmup is cut short.
        write_reg(tdbh_pkg::CFG_WARMUP_COUNT, 16'd255);
        finish_writes();
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'hAAAA);
        pending_samples.push_back(16'h5555);
        settle();
        write_reg(tdbh_pkg::CFG_WARMUP_COUNT, 16'd0);
        finish_writes();
        for (i = 0; i < 30; i++)
        begin
            if (i == 3)
                pending_samples.push_back(16'h0000);
            else if (i == 10)
                pending_samples.push_back(16'hFFFF);
            else
                pending_samples.push_back(16'(1000 + $urandom_range(0, 15)));
        end
        settle();

        b = int'(idle_lvl);
        for (i = 0; i < 3; i++)
            pending_samples.push_back(sat16(b + 100));
        pending_samples.push_back(sat16(b + 500));
        for (i = 0; i < 3; i++)
            pending_samples.push_back(sat16(b));
        settle();

        // Zero-length runs make every sample flip the state between touch and release.
        write_reg(tdbh_pkg::CFG_TOUCH_RUN, 16'd0);
        write_reg(tdbh_pkg::CFG_RELEASE_RUN, 16'd0);
        write_reg(tdbh_pkg::CFG_BLEND_SHIFT, 16'd0);
        finish_writes();
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(sat16(b));
        pending_samples.push_back(sat16(b));
        settle();

        write_reg(tdbh_pkg::CFG_TOUCH_OFFSET, 16'hFFFF);
        write_reg(tdbh_pkg::CFG_RELEASE_OFFSET, 16'hFFFF);
        write_reg(tdbh_pkg::CFG_TOUCH_RUN, 16'd255);
        write_reg(tdbh_pkg::CFG_RELEASE_RUN, 16'd255);
        write_reg(tdbh_pkg::CFG_BLEND_SHIFT, 16'd15);
        finish_writes();
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        settle();

        write_reg(tdbh_pkg::CFG_TOUCH_OFFSET, 16'd0);
        write_reg(tdbh_pkg::CFG_RELEASE_OFFSET, 16'd0);
        write_reg(tdbh_pkg::CFG_TOUCH_RUN, 16'd1);
        write_reg(tdbh_pkg::CFG_RELEASE_RUN, 16'd1);
        write_reg(tdbh_pkg::CFG_BLEND_SHIFT, 16'd1);
        write_reg(tdbh_pkg::CFG_WARMUP_COUNT, 16'd255);
        finish_writes();
        pending_samples.push_back(16'hAAAA);
        pending_samples.push_back(16'h5555);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'h1234);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < RANDOM_PHASES / 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 49;
            end
            else if (ph < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0:       to_val = 16'd0;
                1:       to_val = 16'hFFFF;
                default: to_val = 16'($urandom_range(1, 400));
            endcase
            write_reg(tdbh_pkg::CFG_TOUCH_OFFSET, to_val);
            case ($urandom_range(0, 9))
                0:       write_reg(tdbh_pkg::CFG_RELEASE_OFFSET, 16'd0);
                1:       write_reg(tdbh_pkg::CFG_RELEASE_OFFSET, 16'hFFFF);
                default: write_reg(tdbh_pkg::CFG_RELEASE_OFFSET,
                                   16'($urandom_range(0, int'(to_val))));
            endcase
            write_reg(tdbh_pkg::CFG_TOUCH_RUN, 16'(pick_run()));
            write_reg(tdbh_pkg::CFG_RELEASE_RUN, 16'(pick_run()));
            case ($urandom_range(0, 9))
                0:       write_reg(tdbh_pkg::CFG_BLEND_SHIFT, 16'd0);
                1:       write_reg(tdbh_pkg::CFG_BLEND_SHIFT, 16'd15);
                default: write_reg(tdbh_pkg::CFG_BLEND_SHIFT, 16'($urandom_range(2, 7)));
            endcase
            write_reg(tdbh_pkg::CFG_WARMUP_COUNT, 16'($urandom_range(0, 255)));
            finish_writes();
            b = int'(idle_lvl);
            while (pending_samples.size() < PHASE_SAMPLES)
                add_episode(b);
            settle();
        end

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("Checked %0d results over %0d register settings and %0d register writes,",
                 results_seen, settings_run, reg_writes);
        $display("including calibration, zero-length runs and offset extremes; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("touch_detect_baseline_hysteresis regression: pass");
        else
            $display("touch_detect_baseline_hysteresis regression: fail");
        $finish;
    end

endmodule
